/* rtl/core/tbdd_pkg.sv */
package tbdd_pkg;

   // Crossing phase codes.
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_R1   = 3'd1,
      PH_R0   = 3'd2,
      PH_L1   = 3'd3,
      PH_L0   = 3'd4
   } phase_type;

   // Direction codes, shared by the tentative and the latched direction.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_IN   = 2'd1,
      DIR_OUT  = 2'd2
   } dir_type;

   // Item kind and beam select codes.
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;
   localparam logic BEAM_RIGHT = 1'b0;
   localparam logic BEAM_LEFT  = 1'b1;

   localparam int unsigned RESET_TIME_BITS = 16;
   localparam logic [RESET_TIME_BITS-1:0] RESET_TIME_DEFAULT = 16'd1000;

   // One input word.
   typedef struct packed {
      logic func;
      logic beam_select;
      logic beam_level;
   } item_type;

   // One result word.
   typedef struct packed {
      dir_type   detected_direction;
      logic      detect_pulse;
      phase_type crossing_phase;
      dir_type   tentative_direction;
      logic      timed_out;
   } result_type;

endpackage

/* rtl/core/tbdd_if.sv */
// Input word channel.
interface tbdd_req_if;
   logic valid;
   logic ready;
   logic func;
   logic beam_select;
   logic beam_level;

   modport source (output valid, output func, output beam_select, output beam_level,
                   input ready);
   modport sink   (input valid, input func, input beam_select, input beam_level,
                   output ready);
endinterface

// Result word channel.
interface tbdd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] detected_direction;
   logic       detect_pulse;
   logic [2:0] crossing_phase;
   logic [1:0] tentative_direction;
   logic       timed_out;

   modport source (output valid, output detected_direction, output detect_pulse,
                   output crossing_phase, output tentative_direction, output timed_out,
                   input ready);
   modport sink   (input valid, input detected_direction, input detect_pulse,
                   input crossing_phase, input tentative_direction, input timed_out,
                   output ready);
endinterface

// Configuration write channel carrying the timeout register.
interface tbdd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] reset_time;

   modport source (output valid, output reset_time, input ready);
   modport sink   (input valid, input reset_time, output ready);
endinterface

/* rtl/core/tbdd_core.sv */
module tbdd_core
   import tbdd_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  item_type                   item,
   input  logic [RESET_TIME_BITS-1:0] reset_time,
   output result_type                 result
);

   localparam int unsigned CmpBits =
      (TIMER_BITS > RESET_TIME_BITS) ? TIMER_BITS : RESET_TIME_BITS;

   phase_type             phase_ff, phase_in;
   dir_type               dir_ff, dir_in;
   dir_type               det_ff, det_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0] elapsed_inc;
   phase_type             target;
   logic                  advance;
   logic                  pulse;
   logic                  expired;
   logic                  tmo;

   // Saturating millisecond count and the timeout compare.
   assign elapsed_inc = (elapsed_ff == {TIMER_BITS{1'b1}}) ? elapsed_ff
                                                            : elapsed_ff + 1'b1;
   assign expired = (phase_ff != PH_IDLE) &&
                    (CmpBits'(elapsed_inc) >= CmpBits'(reset_time));

   // Phase that the edge in this word would lead to.
   always_comb begin
      if (item.beam_select == BEAM_LEFT) begin
         target = item.beam_level ? PH_L1 : PH_L0;
      end else begin
         target = item.beam_level ? PH_R1 : PH_R0;
      end
   end

   // Does the edge advance the expected sequence, and does it complete it?
   always_comb begin
      advance = 1'b0;
      pulse   = 1'b0;
      unique case (dir_ff)
         DIR_NONE: begin
            advance = (phase_ff == PH_IDLE) && (target == PH_L1 || target == PH_R1);
         end
         DIR_IN: begin
            advance = (target == PH_R1 && phase_ff == PH_L1) ||
                      (target == PH_L0 && phase_ff == PH_R1) ||
                      (target == PH_R0 && phase_ff == PH_L0);
            pulse   = (target == PH_R0 && phase_ff == PH_L0);
         end
         DIR_OUT: begin
            advance = (target == PH_L1 && phase_ff == PH_R1) ||
                      (target == PH_R0 && phase_ff == PH_L1) ||
                      (target == PH_L0 && phase_ff == PH_R0);
            pulse   = (target == PH_L0 && phase_ff == PH_R0);
         end
         default: begin
            advance = 1'b0;
            pulse   = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      phase_in   = phase_ff;
      dir_in     = dir_ff;
      det_in     = det_ff;
      elapsed_in = elapsed_ff;
      if (item.func == FUNC_TICK) begin
         elapsed_in = elapsed_inc;
         if (expired) begin
            phase_in = PH_IDLE;
            dir_in   = DIR_NONE;
            det_in   = DIR_NONE;
         end
      end else if (advance) begin
         phase_in   = target;
         elapsed_in = '0;
         if (dir_ff == DIR_NONE) begin
            dir_in = (target == PH_L1) ? DIR_IN : DIR_OUT;
         end
         if (pulse) begin
            det_in = dir_ff;
         end
      end
   end

   // Result word for this item.
   always_comb begin
      tmo                        = (item.func == FUNC_TICK) && expired;
      result.detected_direction  = det_in;
      result.detect_pulse        = (item.func == FUNC_EVENT) && pulse;
      result.crossing_phase      = phase_in;
      result.tentative_direction = dir_in;
      result.timed_out           = tmo;
   end

   // State registers, updated once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         dir_ff     <= DIR_NONE;
         det_ff     <= DIR_NONE;
         elapsed_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         dir_ff     <= dir_in;
         det_ff     <= det_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

/* rtl/core/two_beam_direction_detector.sv */
// Direction detector for a doorway watched by a right and a left light barrier.
// Each input word is either a beam level change or a one-millisecond tick, and
// each produces exactly one result word carrying the latched detection, a
// completion pulse, the crossing phase, the tentative direction and a timeout
// flag. A word is taken every clock cycle while the result side does not stall;
// it passes the input register and then the result register before its result
// shows on the result port. The word rate is set by the combinational
// next-state logic in tbdd_core. The timeout register (csr port)
// resets to 1000 and should only be written while no word is in flight.
module two_beam_direction_detector
   import tbdd_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   tbdd_req_if.sink      req_port,
   tbdd_rsp_if.source    rsp_port,
   tbdd_csr_if.sink      csr_port
);

   logic                       in_valid_ff, in_valid_in;
   item_type                   item_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_data_ff;
   result_type                 result;
   logic [RESET_TIME_BITS-1:0] reset_time_ff;
   logic                       req_fire;
   logic                       rsp_free;
   logic                       step;

   // Handshake control for the two register stages.
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign step           = in_valid_ff && rsp_free;
   assign req_port.ready = !in_valid_ff || rsp_free;
   assign req_fire       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      rsp_valid_in = step ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         reset_time_ff <= RESET_TIME_DEFAULT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid && csr_port.ready) begin
            reset_time_ff <= csr_port.reset_time;
         end
      end
   end

   // Input and result word registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func        <= req_port.func;
         item_ff.beam_select <= req_port.beam_select;
         item_ff.beam_level  <= req_port.beam_level;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   // Crossing state and next-state logic.
   tbdd_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item_ff),
      .reset_time (reset_time_ff),
      .result     (result)
   );

   // Result channel outputs.
   assign rsp_port.valid               = rsp_valid_ff;
   assign rsp_port.detected_direction  = rsp_data_ff.detected_direction;
   assign rsp_port.detect_pulse        = rsp_data_ff.detect_pulse;
   assign rsp_port.crossing_phase      = rsp_data_ff.crossing_phase;
   assign rsp_port.tentative_direction = rsp_data_ff.tentative_direction;
   assign rsp_port.timed_out           = rsp_data_ff.timed_out;

endmodule

/* rtl/core/tbdd_checker.sv */
module tbdd_checker
   import tbdd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_detected_direction,
   input logic       rsp_detect_pulse,
   input logic [2:0] rsp_crossing_phase,
   input logic [1:0] rsp_tentative_direction,
   input logic       rsp_timed_out
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_detected_direction, rsp_detect_pulse, rsp_crossing_phase,
                  rsp_tentative_direction, rsp_timed_out}))
      else $error("result word changed while stalled");

   // A completion pulse is only seen in the final phase of its direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detect_pulse |->
         (rsp_detected_direction == DIR_IN && rsp_crossing_phase == PH_R0 &&
          rsp_tentative_direction == DIR_IN) ||
         (rsp_detected_direction == DIR_OUT && rsp_crossing_phase == PH_L0 &&
          rsp_tentative_direction == DIR_OUT))
      else $error("detect pulse outside a completed crossing");

   // A timeout leaves everything cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |->
         rsp_crossing_phase == PH_IDLE && rsp_tentative_direction == DIR_NONE &&
         rsp_detected_direction == DIR_NONE && !rsp_detect_pulse)
      else $error("timeout did not clear the crossing");

   // Idle phase and an empty tentative direction go together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_crossing_phase == PH_IDLE) == (rsp_tentative_direction == DIR_NONE))
      else $error("phase and tentative direction disagree");

   // A latched detection always matches the crossing that produced it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected_direction != DIR_NONE |->
         rsp_tentative_direction == rsp_detected_direction)
      else $error("latched detection differs from crossing direction");

endmodule

bind two_beam_direction_detector tbdd_checker u_tbdd_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_port.valid),
   .rsp_ready               (rsp_port.ready),
   .rsp_detected_direction  (rsp_port.detected_direction),
   .rsp_detect_pulse        (rsp_port.detect_pulse),
   .rsp_crossing_phase      (rsp_port.crossing_phase),
   .rsp_tentative_direction (rsp_port.tentative_direction),
   .rsp_timed_out           (rsp_port.timed_out)
);

/* sim/two_beam_direction_detector_checker.sv */
module two_beam_direction_detector_checker
   import tbdd_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tbdd_req_if         req_port,
   tbdd_rsp_if         rsp_port,
   tbdd_csr_if         csr_port,
   output int unsigned outstanding,
   output int unsigned mismatches
);

   localparam int unsigned REPORT_LIMIT = 10;

   // Own copy of the detector state and of its timeout register.
   phase_type                  cur_phase;
   dir_type                    cur_dir;
   dir_type                    held_detect;
   logic [TIMER_BITS-1:0]      elapsed_ms;
   logic [RESET_TIME_BITS-1:0] timeout_ms;

   result_type  pending_results[$];
   result_type  want;
   result_type  got;
   item_type    taken;
   int unsigned fail_count;

   // Advances the crossing state by one input word and returns its result word.
   function automatic result_type crossing_step(input item_type w);
      result_type r;
      phase_type  goal;
      logic       moved;
      logic       done;
      logic       expired;
      moved   = 1'b0;
      done    = 1'b0;
      expired = 1'b0;
      if (w.func == FUNC_EVENT) begin
         if (w.beam_select == BEAM_LEFT) begin
            goal = w.beam_level ? PH_L1 : PH_L0;
         end else begin
            goal = w.beam_level ? PH_R1 : PH_R0;
         end
         // Only an edge that continues the expected sequence moves the phase.
         case (cur_dir)
            DIR_NONE: begin
               if (cur_phase == PH_IDLE && (goal == PH_L1 || goal == PH_R1)) begin
                  moved   = 1'b1;
                  cur_dir = (goal == PH_L1) ? DIR_IN : DIR_OUT;
               end
            end
            DIR_IN: begin
               moved = (goal == PH_R1 && cur_phase == PH_L1) ||
                       (goal == PH_L0 && cur_phase == PH_R1);
               done  = (goal == PH_R0 && cur_phase == PH_L0);
            end
            DIR_OUT: begin
               moved = (goal == PH_L1 && cur_phase == PH_R1) ||
                       (goal == PH_R0 && cur_phase == PH_L1);
               done  = (goal == PH_L0 && cur_phase == PH_R0);
            end
            default: ;
         endcase
         if (moved || done) begin
            cur_phase  = goal;
            elapsed_ms = '0;
         end
         if (done) begin
            held_detect = cur_dir;
         end
      end else begin
         // The tick counter saturates; the timeout is judged on ticks only.
         if (elapsed_ms != {TIMER_BITS{1'b1}}) begin
            elapsed_ms = elapsed_ms + 1'b1;
         end
         if (cur_phase != PH_IDLE && elapsed_ms >= timeout_ms) begin
            cur_phase   = PH_IDLE;
            cur_dir     = DIR_NONE;
            held_detect = DIR_NONE;
            expired     = 1'b1;
         end
      end
      r.detected_direction  = held_detect;
      r.detect_pulse        = done;
      r.crossing_phase      = cur_phase;
      r.tentative_direction = cur_dir;
      r.timed_out           = expired;
      return r;
   endfunction

   // Watch the three channels, predict on each accepted input word and compare
   // each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         cur_phase   = PH_IDLE;
         cur_dir     = DIR_NONE;
         held_detect = DIR_NONE;
         elapsed_ms  = '0;
         timeout_ms  = RESET_TIME_DEFAULT;
         pending_results.delete();
         fail_count  = 0;
      end else begin
         if (csr_port.valid && csr_port.ready) begin
            timeout_ms = csr_port.reset_time;
         end
         if (rsp_port.valid && rsp_port.ready) begin
            got.detected_direction  = dir_type'(rsp_port.detected_direction);
            got.detect_pulse        = rsp_port.detect_pulse;
            got.crossing_phase      = phase_type'(rsp_port.crossing_phase);
            got.tentative_direction = dir_type'(rsp_port.tentative_direction);
            got.timed_out           = rsp_port.timed_out;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected result word: dir=%0d pulse=%0d phase=%0d tent=%0d tmo=%0d",
                           got.detected_direction, got.detect_pulse, got.crossing_phase,
                           got.tentative_direction, got.timed_out);
               end
            end else begin
               want = pending_results.pop_front();
               if (got.detected_direction !== want.detected_direction ||
                   got.detect_pulse !== want.detect_pulse ||
                   got.crossing_phase !== want.crossing_phase ||
                   got.tentative_direction !== want.tentative_direction ||
                   got.timed_out !== want.timed_out) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display({"result word mismatch: expected dir=%0d pulse=%0d phase=%0d",
                               " tent=%0d tmo=%0d, got dir=%0d pulse=%0d phase=%0d",
                               " tent=%0d tmo=%0d"},
                              want.detected_direction, want.detect_pulse,
                              want.crossing_phase, want.tentative_direction, want.timed_out,
                              got.detected_direction, got.detect_pulse,
                              got.crossing_phase, got.tentative_direction, got.timed_out);
                  end
               end
            end
         end
         if (req_port.valid && req_port.ready) begin
            taken.func        = req_port.func;
            taken.beam_select = req_port.beam_select;
            taken.beam_level  = req_port.beam_level;
            pending_results.push_back(crossing_step(taken));
         end
      end
      outstanding <= pending_results.size();
      mismatches  <= fail_count;
   end

endmodule

/* sim/two_beam_direction_detector_test.sv */
module two_beam_direction_detector_test;
   import tbdd_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 3000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned PHASE_WORDS  = 130;
   localparam int unsigned PHASE_COUNT  = 6;
   localparam int unsigned SETTLE_TICKS = 20;
   localparam int unsigned LONG_TICKS   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned words_sent = 0;
   int unsigned quiet_cycles = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   bit          hold_off_req = 1'b0;

   tbdd_req_if req_bus ();
   tbdd_rsp_if rsp_bus ();
   tbdd_csr_if csr_bus ();

   two_beam_direction_detector u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   two_beam_direction_detector_checker u_watch (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_port    (csr_bus),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Free-running clock with a period of four units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Idle stretches are mostly short, now and then long.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Offers one input word and returns at the edge that accepts it.
   task automatic send_word(input logic f, input logic sel, input logic lvl);
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.beam_select <= sel;
      req_bus.beam_level  <= lvl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   // Waits until every result word is in, then writes the timeout register.
   task automatic write_timeout(input logic [RESET_TIME_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.reset_time <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly complete or truncated crossings with ticks between the edges,
   // mixed with stray words.
   task automatic crossing_traffic(input int unsigned count, input int unsigned limit_ms);
      int unsigned stop_at;
      int unsigned kind;
      int unsigned depth;
      int unsigned ticks;
      logic        lead;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         kind = $urandom_range(0, 9);
         if (kind >= 8) begin
            send_word(coin(), coin(), coin());
         end else begin
            lead  = coin();
            depth = (kind < 6) ? 4 : $urandom_range(1, 3);
            for (int k = 0; k < depth; k++) begin
               ticks = ($urandom_range(0, 9) == 0) ? limit_ms + 1 :
                       $urandom_range(0, limit_ms / 2);
               repeat (ticks) send_word(FUNC_TICK, coin(), coin());
               if ($urandom_range(0, 7) == 0) begin
                  send_word(FUNC_EVENT, coin(), coin());
               end
               send_word(FUNC_EVENT, (k % 2 == 0) ? lead : ~lead, k < 2);
            end
            repeat ($urandom_range(0, limit_ms + 2)) send_word(FUNC_TICK, coin(), coin());
         end
      end
   endtask

   // Result side: random stalls, one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Ends the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("two_beam_direction_detector test failed");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned limits [PHASE_COUNT];
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_EVENT;
      req_bus.beam_select = BEAM_RIGHT;
      req_bus.beam_level  = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.reset_time  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default timeout: clearing edges and a tick in idle are ignored, then a
      // full inward crossing with out-of-order edges that must not count.
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b0);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b0);
      send_word(FUNC_TICK, 1'b1, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b0);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b0);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b0);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b0);
      // A completed crossing stays latched and ignores edges and ticks short of
      // the timeout.
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      repeat (SETTLE_TICKS) send_word(FUNC_TICK, 1'b0, 1'b0);

      // Zero timeout: the first tick outside idle clears the crossing.
      write_timeout('0);
      send_word(FUNC_TICK, 1'b0, 1'b1);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      send_word(FUNC_TICK, 1'b1, 1'b0);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b1);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b0);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b0);
      send_word(FUNC_TICK, 1'b0, 1'b0);

      // Short timeouts: a phase change restarts the elapsed count.
      write_timeout(16'd1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b1);
      send_word(FUNC_TICK, 1'b0, 1'b0);
      write_timeout(16'd3);
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      repeat (2) send_word(FUNC_TICK, 1'b1, 1'b1);
      send_word(FUNC_EVENT, BEAM_LEFT, 1'b1);
      repeat (3) send_word(FUNC_TICK, 1'b1, 1'b1);

      // Random crossings over several timeout settings; the third setting
      // runs back to back with a long hold-off on the result side.
      limits = '{1, 2, 5, $urandom_range(3, 8), $urandom_range(9, 40), 12};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         sender_gaps     = (p != 2);
         receiver_stalls = (p != 4);
         write_timeout(limits[p][RESET_TIME_BITS-1:0]);
         if (p == 2) begin
            hold_off_req = 1'b1;
         end
         crossing_traffic(PHASE_WORDS, limits[p]);
      end

      // Largest timeout: a started crossing holds through a run of ticks.
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      write_timeout({RESET_TIME_BITS{1'b1}});
      send_word(FUNC_EVENT, BEAM_RIGHT, 1'b1);
      repeat (LONG_TICKS) send_word(FUNC_TICK, coin(), coin());

      // Drain and give the verdict.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("two_beam_direction_detector test passed");
      end else begin
         $display("two_beam_direction_detector test failed");
      end
      $finish;
   end

endmodule
